/* design/ric_pkg.sv */
// shared types, constants and arithmetic helpers for the ray / infinite cylinder test
// no dependencies; imported by every ric_* module and the top level
package ric_pkg;

	localparam int SQRT_STEPS  = 32;
	localparam int DIV_STEPS   = 32;
	localparam int QUEUE_DEPTH = 4;

	localparam logic signed [31:0] HALF_RAW = 32'sd32768;
	localparam logic signed [31:0] Q_MAX    = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN    = 32'sh8000_0000;
	localparam logic [47:0]        DISC_MAX = 48'hffff_ffff_ffff;

	// cyclic neighbors for the cross product
	localparam int NXT1 [3] = '{1, 2, 0};
	localparam int NXT2 [3] = '{2, 0, 1};

	typedef enum logic [2:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_AXIS_X   = 3'd3,
		REG_AXIS_Y   = 3'd4,
		REG_AXIS_Z   = 3'd5,
		REG_RADIUS   = 3'd6
	} ric_reg_t;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic signed [17:0] axis_x;
		logic signed [17:0] axis_y;
		logic signed [17:0] axis_z;
		logic [30:0]        radius;
	} ric_cfg_t;

	// one classified ray waiting for the root stage
	typedef struct packed {
		logic               ok;
		logic [47:0]        disc;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] near;
	} ric_qent_t;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] near;
	} ric_sq_side_t;

	// lane 0 is the +sqrt root, lane 1 the -sqrt root
	typedef struct packed {
		logic               ok;
		logic signed [31:0] near;
		logic [1:0]         neg;
		logic [1:0]         ovf;
	} ric_dv_side_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) begin
			r = Q_MAX;
		end else if (x < -64'sd2147483648) begin
			r = Q_MIN;
		end else begin
			r = 32'(x);
		end
		return r;
	endfunction

	// signed, saturated quotient from magnitude, sign and overflow flag
	function automatic logic signed [31:0] root_sat(input logic ovf, input logic neg,
			input logic [31:0] q);
		logic signed [31:0] r;
		if (ovf) begin
			r = neg ? Q_MIN : Q_MAX;
		end else if (neg) begin
			r = (q > 32'h8000_0000) ? Q_MIN : $signed(32'(-q));
		end else begin
			r = q[31] ? Q_MAX : $signed(q);
		end
		return r;
	endfunction

endpackage

/* design/ric_front.sv */
// front pipeline: offsets, cross products, quadratic terms and discriminant
// depends on ric_pkg; feeds ric_queue
module ric_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ric_pkg::ric_cfg_t      cfg,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [31:0]     origin_x,
	input  logic signed [31:0]     origin_y,
	input  logic signed [31:0]     origin_z,
	input  logic signed [17:0]     direction_x,
	input  logic signed [17:0]     direction_y,
	input  logic signed [17:0]     direction_z,
	input  logic signed [31:0]     nearest_distance,
	input  logic                   q_full,
	output logic                   push,
	output ric_pkg::ric_qent_t     push_data
);
	import ric_pkg::*;

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic signed [31:0] org [3];
	logic signed [17:0] dir [3];
	logic signed [31:0] ctr [3];
	logic signed [17:0] ax  [3];

	logic signed [31:0] dist_s1 [3];
	logic signed [17:0] dir_s1 [3];
	logic signed [31:0] near_s1;

	logic signed [49:0] pa_s2 [3];
	logic signed [49:0] pb_s2 [3];
	logic signed [35:0] qa_s2 [3];
	logic signed [35:0] qb_s2 [3];
	logic signed [31:0] near_s2;

	logic signed [31:0] t0_s3 [3];
	logic signed [31:0] t1_s3 [3];
	logic signed [31:0] near_s3;

	logic signed [47:0] p11_s4 [3];
	logic signed [47:0] p10_s4 [3];
	logic signed [47:0] p00_s4 [3];
	logic [45:0]        r2_s4;
	logic signed [31:0] near_s4;

	logic signed [31:0] a_s5, b_s5, c_s5, near_s5;

	logic signed [47:0] bb_s6, ac_s6;
	logic signed [31:0] a_s6, b_s6, near_s6;

	logic [47:0]        disc_s7;
	logic               ok_s7;
	logic signed [31:0] a_s7, b_s7, near_s7;

	logic signed [63:0] sum_a, sum_b, sum_c, disc_w;

	assign org[0] = origin_x;
	assign org[1] = origin_y;
	assign org[2] = origin_z;
	assign dir[0] = direction_x;
	assign dir[1] = direction_y;
	assign dir[2] = direction_z;
	assign ctr[0] = cfg.center_x;
	assign ctr[1] = cfg.center_y;
	assign ctr[2] = cfg.center_z;
	assign ax[0]  = cfg.axis_x;
	assign ax[1]  = cfg.axis_y;
	assign ax[2]  = cfg.axis_z;

	assign adv      = !vld_s7 || !q_full;
	assign in_stall = !adv;
	assign push     = vld_s7 && !q_full;

	assign push_data.ok   = ok_s7;
	assign push_data.disc = disc_s7;
	assign push_data.a    = a_s7;
	assign push_data.b    = b_s7;
	assign push_data.near = near_s7;

	always_comb begin
		sum_a  = 64'(p11_s4[0]) + 64'(p11_s4[1]) + 64'(p11_s4[2]);
		sum_b  = 64'(p10_s4[0]) + 64'(p10_s4[1]) + 64'(p10_s4[2]);
		sum_c  = 64'(p00_s4[0]) + 64'(p00_s4[1]) + 64'(p00_s4[2])
			- $signed(64'(r2_s4));
		disc_w = 64'(bb_s6) - (64'(ac_s6) <<< 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dist_s1[i] <= sat32(64'(org[i]) - 64'(ctr[i]));
				dir_s1[i]  <= dir[i];
				// cross products against the axis, raw terms kept apart
				pa_s2[i] <= 50'(dist_s1[NXT1[i]]) * 50'(ax[NXT2[i]]);
				pb_s2[i] <= 50'(dist_s1[NXT2[i]]) * 50'(ax[NXT1[i]]);
				qa_s2[i] <= 36'(dir_s1[NXT1[i]]) * 36'(ax[NXT2[i]]);
				qb_s2[i] <= 36'(dir_s1[NXT2[i]]) * 36'(ax[NXT1[i]]);
				t0_s3[i] <= sat32((64'(pa_s2[i]) - 64'(pb_s2[i])) >>> 16);
				t1_s3[i] <= sat32((64'(qa_s2[i]) - 64'(qb_s2[i])) >>> 16);
				p11_s4[i] <= 48'((64'(t1_s3[i]) * 64'(t1_s3[i])) >>> 16);
				p10_s4[i] <= 48'((64'(t1_s3[i]) * 64'(t0_s3[i])) >>> 16);
				p00_s4[i] <= 48'((64'(t0_s3[i]) * 64'(t0_s3[i])) >>> 16);
			end
			near_s1 <= nearest_distance;
			near_s2 <= near_s1;
			near_s3 <= near_s2;
			r2_s4   <= 46'((62'(cfg.radius) * 62'(cfg.radius)) >> 16);
			near_s4 <= near_s3;
			a_s5    <= sat32(sum_a);
			b_s5    <= sat32(sum_b <<< 1);
			c_s5    <= sat32(sum_c);
			near_s5 <= near_s4;
			bb_s6   <= 48'((64'(b_s5) * 64'(b_s5)) >>> 16);
			ac_s6   <= 48'((64'(a_s5) * 64'(c_s5)) >>> 16);
			a_s6    <= a_s5;
			b_s6    <= b_s5;
			near_s6 <= near_s5;
			ok_s7   <= !disc_w[63] && (a_s6 != 32'sd0);
			disc_s7 <= (disc_w > $signed(64'(DISC_MAX))) ? DISC_MAX : disc_w[47:0];
			a_s7    <= a_s6;
			b_s7    <= b_s6;
			near_s7 <= near_s6;
		end
	end

endmodule

/* design/ric_queue.sv */
// small fifo that decouples the front pipeline from the root pipeline
// depends on ric_pkg for the entry type and depth
module ric_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ric_pkg::ric_qent_t push_data,
	input  logic               pop,
	output logic               full,
	output logic               nonempty,
	output ric_pkg::ric_qent_t head
);
	import ric_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	ric_qent_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("word pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("word popped from empty queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("queue count lost a push");

endmodule

/* design/ric_isqrt.sv */
// pipelined integer square root, one result bit per stage
// depends on ric_pkg; used by ric_back
module ric_isqrt (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [47:0]           radicand,
	input  ric_pkg::ric_sq_side_t side_in,
	output logic                  out_vld,
	output logic [31:0]           root,
	output ric_pkg::ric_sq_side_t side_out
);
	import ric_pkg::*;

	logic         vld_s  [SQRT_STEPS];
	logic [63:0]  n_s    [SQRT_STEPS];
	logic [33:0]  rem_s  [SQRT_STEPS];
	logic [31:0]  root_s [SQRT_STEPS];
	ric_sq_side_t side_s [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		logic         vld_i;
		logic [63:0]  n_i;
		logic [33:0]  rem_i;
		logic [31:0]  root_i;
		ric_sq_side_t side_i;
		logic [35:0]  rem_sh, trial, diff;
		logic         ge;

		if (k == 0) begin : g_head
			// radicand in Q16.16 is the raw value shifted up by 16
			assign vld_i  = in_vld;
			assign n_i    = {radicand, 16'h0000};
			assign rem_i  = '0;
			assign root_i = '0;
			assign side_i = side_in;
		end else begin : g_tail
			assign vld_i  = vld_s[k-1];
			assign n_i    = n_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign rem_sh = {rem_i, n_i[63:62]};
		assign trial  = {2'b00, root_i, 2'b01};
		assign ge     = (rem_sh >= trial);
		assign diff   = rem_sh - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k]    <= n_i << 2;
				rem_s[k]  <= ge ? diff[33:0] : rem_sh[33:0];
				root_s[k] <= {root_i[30:0], ge};
				side_s[k] <= side_i;
			end
		end
	end

	assign out_vld  = vld_s[SQRT_STEPS-1];
	assign root     = root_s[SQRT_STEPS-1];
	assign side_out = side_s[SQRT_STEPS-1];

endmodule

/* design/ric_div.sv */
// two-lane pipelined restoring divider, one quotient bit per stage
// depends on ric_pkg; used by ric_back for both roots
module ric_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [33:0]           mag_p,
	input  logic [33:0]           mag_m,
	input  logic [32:0]           den,
	input  ric_pkg::ric_dv_side_t side_in,
	output logic                  out_vld,
	output logic [31:0]           quo_p,
	output logic [31:0]           quo_m,
	output ric_pkg::ric_dv_side_t side_out
);
	import ric_pkg::*;

	logic         vld_s  [DIV_STEPS];
	logic [32:0]  den_s  [DIV_STEPS];
	ric_dv_side_t side_s [DIV_STEPS];
	logic [33:0]  rem_s  [DIV_STEPS][2];
	logic [31:0]  lo_s   [DIV_STEPS][2];
	logic [31:0]  quo_s  [DIV_STEPS][2];
	logic [33:0]  mag_in [2];

	assign mag_in[0] = mag_p;
	assign mag_in[1] = mag_m;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic         vld_i;
		logic [32:0]  den_i;
		ric_dv_side_t side_i;

		if (k == 0) begin : g_head
			assign vld_i  = in_vld;
			assign den_i  = den;
			assign side_i = side_in;
		end else begin : g_tail
			assign vld_i  = vld_s[k-1];
			assign den_i  = den_s[k-1];
			assign side_i = side_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k]  <= den_i;
				side_s[k] <= side_i;
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [33:0] rem_i;
			logic [31:0] lo_i, quo_i;
			logic [34:0] rem_sh, diff;
			logic        ge;

			if (k == 0) begin : g_head
				// dividend is the magnitude times 2^16; its top part seeds the remainder
				assign rem_i = {16'h0000, mag_in[l][33:16]};
				assign lo_i  = {mag_in[l][15:0], 16'h0000};
				assign quo_i = '0;
			end else begin : g_tail
				assign rem_i = rem_s[k-1][l];
				assign lo_i  = lo_s[k-1][l];
				assign quo_i = quo_s[k-1][l];
			end

			assign rem_sh = {rem_i, lo_i[31]};
			assign ge     = (rem_sh >= {2'b00, den_i});
			assign diff   = rem_sh - {2'b00, den_i};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= ge ? diff[33:0] : rem_sh[33:0];
					lo_s[k][l]  <= lo_i << 1;
					quo_s[k][l] <= {quo_i[30:0], ge};
				end
			end
		end
	end

	assign out_vld  = vld_s[DIV_STEPS-1];
	assign quo_p    = quo_s[DIV_STEPS-1][0];
	assign quo_m    = quo_s[DIV_STEPS-1][1];
	assign side_out = side_s[DIV_STEPS-1];

endmodule

/* design/ric_back.sv */
// back pipeline: square root, both roots, nearest-root pick and output register
// depends on ric_pkg, ric_isqrt and ric_div
module ric_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_vld,
	input  ric_pkg::ric_qent_t q_head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic signed [31:0] new_distance
);
	import ric_pkg::*;

	logic               adv;
	ric_sq_side_t       sq_side_in, sq_side;
	logic               sq_vld;
	logic [31:0]        sq_root;

	logic signed [33:0] b_x, s_x, num_p, num_m;
	logic [33:0]        mag_p, mag_m;
	logic [32:0]        den;

	logic               vld_s1;
	logic [33:0]        mag_p_s1, mag_m_s1;
	logic [32:0]        den_s1;
	ric_dv_side_t       side_s1;

	logic               dv_vld;
	logic [31:0]        quo_p, quo_m;
	ric_dv_side_t       dv_side;

	logic signed [31:0] xp, xm, x;
	logic [31:0]        ap, am;
	logic               hit_w;

	logic               out_vld_q, hit_q;
	logic signed [31:0] dist_q;

	assign adv = !out_vld_q || !out_stall;
	assign pop = adv && q_vld;

	assign sq_side_in.ok   = q_head.ok;
	assign sq_side_in.a    = q_head.a;
	assign sq_side_in.b    = q_head.b;
	assign sq_side_in.near = q_head.near;

	ric_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (q_vld),
		.radicand (q_head.disc),
		.side_in  (sq_side_in),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.side_out (sq_side)
	);

	// numerators -b +/- s, split into sign and magnitude for the divider
	always_comb begin
		b_x   = 34'(sq_side.b);
		s_x   = $signed({2'b00, sq_root});
		num_p = s_x - b_x;
		num_m = -s_x - b_x;
		mag_p = num_p[33] ? 34'(-num_p) : 34'(num_p);
		mag_m = num_m[33] ? 34'(-num_m) : 34'(num_m);
		den   = {sq_side.a, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_p_s1     <= mag_p;
			mag_m_s1     <= mag_m;
			den_s1       <= den;
			side_s1.ok   <= sq_side.ok;
			side_s1.near <= sq_side.near;
			side_s1.neg  <= {num_m[33], num_p[33]};
			// quotient of 2^32 or more saturates whatever its low bits
			side_s1.ovf  <= {({15'h0000, mag_m[33:16]} >= den),
				({15'h0000, mag_p[33:16]} >= den)};
		end
	end

	ric_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s1),
		.mag_p    (mag_p_s1),
		.mag_m    (mag_m_s1),
		.den      (den_s1),
		.side_in  (side_s1),
		.out_vld  (dv_vld),
		.quo_p    (quo_p),
		.quo_m    (quo_m),
		.side_out (dv_side)
	);

	always_comb begin
		xp    = root_sat(dv_side.ovf[0], dv_side.neg[0], quo_p);
		xm    = root_sat(dv_side.ovf[1], dv_side.neg[1], quo_m);
		ap    = xp[31] ? 32'(-xp) : 32'(xp);
		am    = xm[31] ? 32'(-xm) : 32'(xm);
		// ties go to the +sqrt root
		x     = (ap > am) ? xm : xp;
		hit_w = dv_side.ok && (x > HALF_RAW) && (x < dv_side.near);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q  <= hit_w;
			dist_q <= hit_w ? x : dv_side.near;
		end
	end

	assign out_valid    = out_vld_q;
	assign hit          = hit_q;
	assign new_distance = dist_q;

endmodule

/* design/ray_infinite_cylinder_intersect.sv */
// an accepted ray passes the front pipeline, the queue, the root and divider pipelines and the output register
// throughput: one ray per cycle while no stall holds the flow; the root and divider pipelines are 32 stages each
// a 4-word queue between front and back absorbs output stall before the input stalls
// reset: pipelines and queue empty, cylinder registers at center 0, axis +y, radius 1.0
// depends on ric_pkg, ric_front, ric_queue, ric_back
module ray_infinite_cylinder_intersect (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [17:0] direction_x,
	input  logic signed [17:0] direction_y,
	input  logic signed [17:0] direction_z,
	input  logic signed [31:0] nearest_distance,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic signed [31:0] new_distance
);
	import ric_pkg::*;

	ric_cfg_t  cfg_q;
	logic      q_full, q_nonempty, push, pop;
	ric_qent_t push_data, q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x <= '0;
			cfg_q.center_y <= '0;
			cfg_q.center_z <= '0;
			cfg_q.axis_x   <= '0;
			cfg_q.axis_y   <= 18'sd65536;
			cfg_q.axis_z   <= '0;
			cfg_q.radius   <= 31'd65536;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CENTER_X: cfg_q.center_x <= cfg_data;
				REG_CENTER_Y: cfg_q.center_y <= cfg_data;
				REG_CENTER_Z: cfg_q.center_z <= cfg_data;
				REG_AXIS_X:   cfg_q.axis_x   <= cfg_data[17:0];
				REG_AXIS_Y:   cfg_q.axis_y   <= cfg_data[17:0];
				REG_AXIS_Z:   cfg_q.axis_z   <= cfg_data[17:0];
				REG_RADIUS:   cfg_q.radius   <= cfg_data[30:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	ric_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.origin_x         (origin_x),
		.origin_y         (origin_y),
		.origin_z         (origin_z),
		.direction_x      (direction_x),
		.direction_y      (direction_y),
		.direction_z      (direction_z),
		.nearest_distance (nearest_distance),
		.q_full           (q_full),
		.push             (push),
		.push_data        (push_data)
	);

	ric_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	ric_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_vld        (q_nonempty),
		.q_head       (q_head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.new_distance (new_distance)
	);

endmodule

/* sim/ric_checker.sv */
// watches the config, ray and result channels of ray_infinite_cylinder_intersect
// predicts every result word from its own copy of the cylinder registers; depends on ric_pkg
`timescale 1ns / 1ps
module ric_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [17:0] direction_x,
	input  logic signed [17:0] direction_y,
	input  logic signed [17:0] direction_z,
	input  logic signed [31:0] nearest_distance,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               hit,
	input  logic signed [31:0] new_distance,
	output int                 errors,
	output int                 pending
);
	import ric_pkg::*;

	typedef struct {
		logic        hit;
		logic [31:0] new_dist;
	} hit_word_t;

	hit_word_t   expected_hits[$];
	longint      cyl_center[3];
	longint      cyl_axis[3];
	longint      cyl_radius;

	function automatic longint clamp32(input longint x);
		if (x > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return x;
	endfunction

	function automatic longint floor16(input longint x);
		return x >>> 16;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic hit_word_t intersect_ray(input longint o[3], input longint d[3],
			input longint near);
		longint    rel[3], t0[3], t1[3];
		longint    a, b, c, disc, s, den, xp, xm, ap, am, x;
		hit_word_t w;
		for (int i = 0; i < 3; i++) rel[i] = clamp32(o[i] - cyl_center[i]);
		for (int i = 0; i < 3; i++) begin
			t0[i] = clamp32(floor16(rel[(i+1)%3] * cyl_axis[(i+2)%3]
				- rel[(i+2)%3] * cyl_axis[(i+1)%3]));
			t1[i] = clamp32(floor16(d[(i+1)%3] * cyl_axis[(i+2)%3]
				- d[(i+2)%3] * cyl_axis[(i+1)%3]));
		end
		a = 0; b = 0; c = 0;
		for (int i = 0; i < 3; i++) begin
			a += floor16(t1[i] * t1[i]);
			b += floor16(t1[i] * t0[i]);
			c += floor16(t0[i] * t0[i]);
		end
		a = clamp32(a);
		b = clamp32(2 * b);
		c = clamp32(c - floor16(cyl_radius * cyl_radius));
		disc = floor16(b * b) - 4 * floor16(a * c);
		w.hit = 1'b0;
		w.new_dist = near[31:0];
		if (disc >= 0 && a != 0) begin
			if (disc > longint'(DISC_MAX)) disc = longint'(DISC_MAX);
			s = longint'(int_sqrt(longint'(unsigned'(disc)) << 16));
			den = 2 * a;
			xp = clamp32(((-b + s) * 65536) / den);
			xm = clamp32(((-b - s) * 65536) / den);
			ap = xp < 0 ? -xp : xp;
			am = xm < 0 ? -xm : xm;
			x = (ap > am) ? xm : xp;
			if (x > longint'(HALF_RAW) && x < near) begin
				w.hit = 1'b1;
				w.new_dist = x[31:0];
			end
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		longint    o[3], d[3];
		hit_word_t w;
		if (!arst_n) begin
			cyl_center = '{0, 0, 0};
			cyl_axis = '{0, 65536, 0};
			cyl_radius = 65536;
			expected_hits.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CENTER_X: cyl_center[0] = longint'($signed(cfg_data));
					REG_CENTER_Y: cyl_center[1] = longint'($signed(cfg_data));
					REG_CENTER_Z: cyl_center[2] = longint'($signed(cfg_data));
					REG_AXIS_X:   cyl_axis[0] = longint'($signed(cfg_data[17:0]));
					REG_AXIS_Y:   cyl_axis[1] = longint'($signed(cfg_data[17:0]));
					REG_AXIS_Z:   cyl_axis[2] = longint'($signed(cfg_data[17:0]));
					REG_RADIUS:   cyl_radius = longint'(cfg_data[30:0]);
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				o = '{origin_x, origin_y, origin_z};
				d = '{direction_x, direction_y, direction_z};
				expected_hits.push_back(intersect_ray(o, d, nearest_distance));
			end
			if (out_valid && !out_stall) begin
				if (expected_hits.size() == 0) begin
					// result word with nothing expected
					report_mismatch("result count", 1, 0);
				end else begin
					w = expected_hits.pop_front();
					if (hit !== w.hit) report_mismatch("hit", hit, w.hit);
					if (new_distance !== w.new_dist)
						report_mismatch("new_distance", new_distance, $signed(w.new_dist));
				end
			end
			pending = expected_hits.size();
		end
	end

endmodule

/* sim/tb_top.sv */
// stimulus and verdict for ray_infinite_cylinder_intersect: directed and random rays
// over several cylinder settings; depends on ric_pkg, the design and ric_checker
`timescale 1ns / 1ps
module tb_top;
	import ric_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam longint ONE = 65536;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] origin_x, origin_y, origin_z;
	logic signed [17:0] direction_x, direction_y, direction_z;
	logic signed [31:0] nearest_distance;
	logic               out_valid;
	logic               out_stall;
	logic               hit;
	logic signed [31:0] new_distance;
	int                 errors;
	int                 pending;
	int                 hold_left;
	bit                 send_steady;

	ray_infinite_cylinder_intersect i_dut (.*);

	ric_checker i_checker (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	// receiver stall: quiet stretches, short blips, the odd long hold
	initial begin
		int seg, mode, run;
		out_stall = 1'b0;
		hold_left = 0;
		seg = 0;
		run = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (seg == 0) begin
					mode = $urandom_range(0, 2);
					seg = $urandom_range(20, 200);
				end
				seg--;
				if (run == 0 && mode != 0) begin
					if ($urandom_range(0, 3) == 0) run = $urandom_range(1, 3);
					else if (mode == 2 && $urandom_range(0, 40) == 0)
						run = $urandom_range(10, 40);
				end
				if (run > 0) run--;
				out_stall <= (run > 0);
			end
		end
	end

	function automatic int gap_len();
		if (send_steady || $urandom_range(0, 2) != 0) return 0;
		if ($urandom_range(0, 30) == 0) return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// fields are cut to their port widths here
	task automatic send_ray(input longint ox, oy, oz, dx, dy, dz, near);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		origin_x <= ox[31:0];
		origin_y <= oy[31:0];
		origin_z <= oz[31:0];
		direction_x <= dx[17:0];
		direction_y <= dy[17:0];
		direction_z <= dz[17:0];
		nearest_distance <= near[31:0];
		forever begin
			@(negedge clk);
			if (!in_stall) break;
			@(posedge clk);
		end
		@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		forever begin
			@(negedge clk);
			if (cfg_ready) break;
			@(posedge clk);
		end
		@(posedge clk);
	endtask

	task automatic set_cylinder(input longint cx, cy, cz, ax, ay, az, rad);
		wait_drained();
		write_reg(REG_CENTER_X, cx[31:0]);
		write_reg(REG_CENTER_Y, cy[31:0]);
		write_reg(REG_CENTER_Z, cz[31:0]);
		write_reg(REG_AXIS_X, ax[31:0]);
		write_reg(REG_AXIS_Y, ay[31:0]);
		write_reg(REG_AXIS_Z, az[31:0]);
		write_reg(REG_RADIUS, rad[31:0]);
		write_reg(REG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
	endtask

	function automatic longint rand_span(input longint span);
		return longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic random_rays(input int count);
		longint ox, oy, oz, near;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 4) == 0) begin
				send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else begin
				ox = rand_span(8 * ONE);
				oy = rand_span(8 * ONE);
				oz = rand_span(8 * ONE);
				near = ($urandom_range(0, 3) == 0) ? rand_span(16 * ONE) : 32'sh7fff_ffff;
				send_ray(ox, oy, oz, rand_span(ONE), rand_span(ONE), rand_span(ONE), near);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		origin_x = '0;
		origin_y = '0;
		origin_z = '0;
		direction_x = '0;
		direction_y = '0;
		direction_z = '0;
		nearest_distance = '0;
		send_steady = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset cylinder: axis +y through the origin, radius 1.0
		send_ray(-5 * ONE, 0, 0, ONE, 0, 0, 32'sh7fff_ffff);
		send_ray(-5 * ONE, 0, ONE, ONE, 0, 0, 32'sh7fff_ffff);    // tangent, double root
		send_ray(-5 * ONE, 0, 0, 0, ONE, 0, 32'sh7fff_ffff);      // parallel to axis
		send_ray(-5 * ONE, 0, 3 * ONE, ONE, 0, 0, 32'sh7fff_ffff); // clean miss
		send_ray(0, 7 * ONE, 0, ONE, 0, 0, 32'sh7fff_ffff);       // on axis, roots of equal size
		send_ray(3 * ONE / 4, 0, 0, ONE, 0, 0, 32'sh7fff_ffff);   // root under one half
		send_ray(-5 * ONE, 0, 0, ONE, 0, 0, 2 * ONE);             // nearer hit already
		send_ray(-5 * ONE, 0, 0, ONE, 0, 0, 32'sh8000_0000);
		send_ray(-5 * ONE, 0, 0, -ONE, 0, 0, 32'sh7fff_ffff);     // pointing away
		send_ray(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
			18'sh1ffff, 18'sh1ffff, 18'sh1ffff, 32'sh7fff_ffff);
		send_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			18'sh20000, 18'sh20000, 18'sh20000, 32'sh7fff_ffff);
		send_ray(32'sh8000_0000, 0, 32'sh7fff_ffff, -ONE, ONE, ONE, 32'sh7fff_ffff);
		send_ray(-ONE / 2, 0, 0, 18'sh00001, 0, 0, 32'sh7fff_ffff); // tiny direction

		// huge radius, far center: huge discriminant and saturation
		set_cylinder(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, ONE, 0, 0, 32'h7fff_ffff);
		send_ray(0, 0, 0, 0, ONE, 0, 32'sh7fff_ffff);
		send_ray(32'sh8000_0000, 0, 32'sh8000_0000, 0, 18'sh1ffff, 18'sh20000, 32'sh7fff_ffff);
		send_ray(0, 0, 0, 0, -ONE, -ONE, 32'sh7fff_ffff);
		random_rays(150);

		// zero radius, oversized axis
		set_cylinder(32'sh8000_0000, 0, 32'sh8000_0000, 18'sh20000, 18'sh1ffff, -ONE, 0);
		send_ray(32'sh8000_0000, 0, 32'sh8000_0000, 0, ONE, 0, 32'sh7fff_ffff);
		random_rays(150);

		// back to a cylinder of radius 2.0 along +z, with the long output hold
		set_cylinder(ONE, -ONE, 0, 0, 0, ONE, 2 * ONE);
		send_steady = 1'b1;
		@(negedge clk);
		hold_left = 300;
		random_rays(60);
		send_steady = 1'b0;
		random_rays(240);

		for (int phase = 0; phase < 4; phase++) begin
			set_cylinder(rand_span(4 * ONE), rand_span(4 * ONE), rand_span(4 * ONE),
				rand_span(ONE), rand_span(ONE), rand_span(ONE),
				$urandom_range(0, 6 * ONE));
			random_rays(100);
			wait_drained();
			random_rays(50);
		end

		wait_drained();
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
design/ric_pkg.sv
design/ric_front.sv
design/ric_queue.sv
design/ric_isqrt.sv
design/ric_div.sv
design/ric_back.sv
design/ray_infinite_cylinder_intersect.sv
sim/ric_checker.sv
sim/tb_top.sv
